// ===== hw/rtl/nip_pkg.sv =====
// ----------------------------------------------------------------------------
// nip_pkg
// Shared types, constants and helpers of the pulse pair decoder.
// ----------------------------------------------------------------------------
package nip_pkg;

  // Field widths.
  localparam int TICK_W   = 15;
  localparam int SEG_W    = 11;
  localparam int TOL_W    = 10;
  localparam int ADDR_W   = 16;
  localparam int CMD_W    = 8;
  localparam int STATUS_W = 2;
  localparam int NOM_W    = 17;
  localparam int COUNT_W  = 6;
  localparam int SHIFT_W  = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd1;

  localparam logic [SEG_W-1:0] SEGMENT_RESET   = 11'd563;
  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 10'd100;

  // Burst lengths.
  localparam logic [COUNT_W-1:0] PAIR_SAT     = 6'd35;
  localparam logic [COUNT_W-1:0] FRAME_PAIRS  = 6'd34;
  localparam logic [COUNT_W-1:0] REPEAT_PAIRS = 6'd2;
  localparam logic [COUNT_W-1:0] LAST_DATA    = 6'd32;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FRAME_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REPEAT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_NEC   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CHECK_BAD = 2'd3;

  localparam logic [ADDR_W-1:0] REPEAT_ADDR = 16'hffff;
  localparam logic [CMD_W-1:0]  REPEAT_CMD  = 8'hff;

  // Depth of the queue between classifier and burst tracker.
  localparam int QUEUE_DEPTH = 2;

  // One classified pulse pair.
  typedef struct packed {
    logic lead_frame;
    logic lead_repeat;
    logic bit_one;
    logic last;
  } pair_class_t;

  // True when v lies strictly inside nom +/- tol.
  function automatic logic in_window(input logic [TICK_W-1:0] v,
                                     input logic [NOM_W-1:0]  nom,
                                     input logic [TOL_W-1:0]  tol);
    logic [NOM_W-1:0] v_ext;
    logic [NOM_W-1:0] t_ext;
    v_ext = NOM_W'(v);
    t_ext = NOM_W'(tol);
    return ((v_ext + t_ext) > nom) && (v_ext < (nom + t_ext));
  endfunction

endpackage

// ===== hw/rtl/nip_front.sv =====
// ----------------------------------------------------------------------------
// nip_front
// Holds the timing registers and classifies each pulse pair request
// against the leader and data bit windows.
// ----------------------------------------------------------------------------
module nip_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nip_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [nip_pkg::TICK_W-1:0]        low_ticks,
  input  logic [nip_pkg::TICK_W-1:0]        high_ticks,
  input  logic                              last,
  output nip_pkg::pair_class_t              pair_class
);

  logic [nip_pkg::SEG_W-1:0] segment_r;
  logic [nip_pkg::TOL_W-1:0] tolerance_r;
  logic [nip_pkg::NOM_W-1:0] nom16;
  logic [nip_pkg::NOM_W-1:0] nom8;
  logic [nip_pkg::NOM_W-1:0] nom4;
  logic [nip_pkg::NOM_W-1:0] nom3;
  logic                      lead_low_ok;

  // Timing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_r   <= nip_pkg::SEGMENT_RESET;
      tolerance_r <= nip_pkg::TOLERANCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nip_pkg::REG_SEGMENT:   segment_r   <= cfg_wdata;
        nip_pkg::REG_TOLERANCE: tolerance_r <= cfg_wdata[nip_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Nominal durations as multiples of one segment.
  assign nom16 = nip_pkg::NOM_W'({segment_r, 4'b0000});
  assign nom8  = nip_pkg::NOM_W'({segment_r, 3'b000});
  assign nom4  = nip_pkg::NOM_W'({segment_r, 2'b00});
  assign nom3  = nip_pkg::NOM_W'({segment_r, 1'b0}) + nip_pkg::NOM_W'(segment_r);

  // Window checks for both leader forms and for a one bit.
  assign lead_low_ok = nip_pkg::in_window(low_ticks, nom16, tolerance_r);

  always_comb begin
    pair_class.lead_frame  = lead_low_ok && nip_pkg::in_window(high_ticks, nom8, tolerance_r);
    pair_class.lead_repeat = lead_low_ok && nip_pkg::in_window(high_ticks, nom4, tolerance_r);
    pair_class.bit_one     = nip_pkg::in_window(high_ticks, nom3, tolerance_r);
    pair_class.last        = last;
  end

endmodule

// ===== hw/rtl/nip_queue.sv =====
// ----------------------------------------------------------------------------
// nip_queue
// Small first-in first-out queue of classified pulse pairs.
// ----------------------------------------------------------------------------
module nip_queue #(
  parameter int DEPTH = nip_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  nip_pkg::pair_class_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output nip_pkg::pair_class_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nip_pkg::pair_class_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/nip_back.sv =====
// ----------------------------------------------------------------------------
// nip_back
// Tracks one burst of classified pairs, collects the data bits and
// registers one result on the last pair.
// ----------------------------------------------------------------------------
module nip_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pair_valid,
  output logic                             pair_ready,
  input  nip_pkg::pair_class_t             pair_class,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nip_pkg::STATUS_W-1:0]     out_status,
  output logic [nip_pkg::ADDR_W-1:0]       out_address,
  output logic [nip_pkg::CMD_W-1:0]        out_command
);

  logic [nip_pkg::COUNT_W-1:0]  pair_cnt_r;
  logic [nip_pkg::SHIFT_W-1:0]  bit_shift_r;
  logic                         frame_ok_r;
  logic                         repeat_ok_r;
  logic                         out_valid_r;
  logic [nip_pkg::STATUS_W-1:0] status_r;
  logic [nip_pkg::ADDR_W-1:0]   address_r;
  logic [nip_pkg::CMD_W-1:0]    command_r;

  logic [nip_pkg::COUNT_W-1:0]  pair_cnt_nxt;
  logic [nip_pkg::SHIFT_W-1:0]  bit_shift_nxt;
  logic                         frame_ok_nxt;
  logic                         repeat_ok_nxt;
  logic [nip_pkg::COUNT_W-1:0]  cnt_inc;
  logic [nip_pkg::STATUS_W-1:0] status_nxt;
  logic [nip_pkg::ADDR_W-1:0]   address_nxt;
  logic [nip_pkg::CMD_W-1:0]    command_nxt;
  logic [7:0]                   b0;
  logic [7:0]                   b1;
  logic [7:0]                   b2;
  logic [7:0]                   b3;
  logic                         take;

  // A pair is taken whenever the result register is free or draining.
  assign pair_ready = !out_valid_r || out_ready;
  assign take       = pair_valid && pair_ready;

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_address = address_r;
  assign out_command = command_r;

  // Burst state update.
  always_comb begin
    cnt_inc       = (pair_cnt_r < nip_pkg::PAIR_SAT) ? pair_cnt_r + 1'b1 : pair_cnt_r;
    frame_ok_nxt  = frame_ok_r;
    repeat_ok_nxt = repeat_ok_r;
    bit_shift_nxt = bit_shift_r;
    if (pair_cnt_r == '0) begin
      frame_ok_nxt  = pair_class.lead_frame;
      repeat_ok_nxt = pair_class.lead_repeat;
    end else if (pair_cnt_r <= nip_pkg::LAST_DATA) begin
      // Data bits enter at the top, so the first one ends at bit 0.
      bit_shift_nxt = {pair_class.bit_one, bit_shift_r[nip_pkg::SHIFT_W-1:1]};
    end
    pair_cnt_nxt = cnt_inc;
    if (pair_class.last) begin
      pair_cnt_nxt  = '0;
      bit_shift_nxt = '0;
      frame_ok_nxt  = 1'b0;
      repeat_ok_nxt = 1'b0;
    end
  end

  // Result decode for the last pair of a burst.
  assign b0 = bit_shift_r[7:0];
  assign b1 = bit_shift_r[15:8];
  assign b2 = bit_shift_r[23:16];
  assign b3 = bit_shift_r[31:24];

  always_comb begin
    if (cnt_inc == nip_pkg::FRAME_PAIRS && frame_ok_r) begin
      address_nxt = ((b0 & b1) == 8'd0) ? {8'd0, b0} : {b1, b0};
      command_nxt = b2;
      status_nxt  = ((b2 & b3) == 8'd0) ? nip_pkg::ST_FRAME_OK : nip_pkg::ST_CHECK_BAD;
    end else if (cnt_inc == nip_pkg::REPEAT_PAIRS && repeat_ok_r) begin
      address_nxt = nip_pkg::REPEAT_ADDR;
      command_nxt = nip_pkg::REPEAT_CMD;
      status_nxt  = nip_pkg::ST_REPEAT;
    end else begin
      address_nxt = '0;
      command_nxt = '0;
      status_nxt  = nip_pkg::ST_NOT_NEC;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_cnt_r  <= '0;
      bit_shift_r <= '0;
      frame_ok_r  <= 1'b0;
      repeat_ok_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        pair_cnt_r  <= pair_cnt_nxt;
        bit_shift_r <= bit_shift_nxt;
        frame_ok_r  <= frame_ok_nxt;
        repeat_ok_r <= repeat_ok_nxt;
      end
      if (take && pair_class.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take && pair_class.last) begin
      status_r  <= status_nxt;
      address_r <= address_nxt;
      command_r <= command_nxt;
    end
  end

endmodule

// ===== hw/rtl/nec_ir_pulse_decoder_core.sv =====
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_core
// Decodes bursts of measured infrared pulse pairs into address, command
// and status results.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | valid / ready      | low_ticks, high_ticks, last
//   out_    | output    | valid / ready      | status, address, command
//   cfg_    | input     | write enable only  | segment (0), tolerance (1)
//
// One pulse pair request is accepted per cycle while the queue has room. The
// window compares feed the queue directly, the last pair of a burst is
// written into the queue, and the burst tracker registers the result when it
// takes that pair from the queue. Reset clears the burst state and loads the
// timing registers with 563 and 100 ticks. A stalled output holds its result
// while the queue of classified pairs keeps accepting until full.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder_core #(
  parameter int QUEUE_DEPTH = nip_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nip_pkg::TICK_W-1:0]        in_low_ticks,
  input  logic [nip_pkg::TICK_W-1:0]        in_high_ticks,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nip_pkg::STATUS_W-1:0]      out_status,
  output logic [nip_pkg::ADDR_W-1:0]        out_address,
  output logic [nip_pkg::CMD_W-1:0]         out_command,
  input  logic                              cfg_we,
  input  logic [nip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nip_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  nip_pkg::pair_class_t front_class;
  nip_pkg::pair_class_t queue_class;
  logic                 queue_valid;
  logic                 queue_ready;

  // Classifier with timing registers.
  nip_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .low_ticks  (in_low_ticks),
    .high_ticks (in_high_ticks),
    .last       (in_last),
    .pair_class (front_class)
  );

  // Queue between classifier and burst tracker.
  nip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_class),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_class)
  );

  // Burst tracker and result register.
  nip_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pair_valid  (queue_valid),
    .pair_ready  (queue_ready),
    .pair_class  (queue_class),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_address (out_address),
    .out_command (out_command)
  );

endmodule
